### sv/blid_pkg.sv
// ----------------------------------------------------------------------------
// Bounded list package
// Shared constants, operation codes, state codes and the cell control word
// used by the bounded list blocks.
// ----------------------------------------------------------------------------
package blid_pkg;

   // Default number of list entries.
   localparam int CAPACITY_DEF = 16;

   // Field widths fixed by the stream format.
   localparam int VALUE_W    = 32;
   localparam int POSITION_W = 8;
   localparam int INDEX_W    = 4;
   localparam int OP_W       = 2;

   // Operation codes carried in the request tuser field.
   typedef enum logic [OP_W-1:0] {
      OP_INSERT_FRONT = 2'd0,
      OP_APPEND_BACK  = 2'd1,
      OP_DELETE_AT    = 2'd2
   } op_type;

   // Sequencer states.
   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_DUMP = 1'b1
   } state_type;

   // Per-cell control: where the cell takes its next value from.
   typedef struct packed {
      logic load;        // take the request value
      logic take_left;   // take the value of the cell before it
      logic take_right;  // take the value of the cell after it
      logic take_head;   // take the value of the head cell (ring wrap)
   } cell_ctl_type;

endpackage

### sv/blid_cell.sv
// ----------------------------------------------------------------------------
// Bounded list cell
// Holds one list entry and moves it to or from its neighbors on command.
// ----------------------------------------------------------------------------
module blid_cell (
   input  logic                                   clock,
   input  blid_pkg::cell_ctl_type                 ctl,
   input  logic [blid_pkg::VALUE_W-1:0]           load_value,
   input  logic [blid_pkg::VALUE_W-1:0]           left_value,
   input  logic [blid_pkg::VALUE_W-1:0]           right_value,
   input  logic [blid_pkg::VALUE_W-1:0]           head_value,
   output logic [blid_pkg::VALUE_W-1:0]           value_out
);

   logic [blid_pkg::VALUE_W-1:0] value_ff;
   logic [blid_pkg::VALUE_W-1:0] value_in;

   // Select the source of the next entry value.
   always_comb begin
      if (ctl.load) begin
         value_in = load_value;
      end else if (ctl.take_left) begin
         value_in = left_value;
      end else if (ctl.take_right) begin
         value_in = right_value;
      end else if (ctl.take_head) begin
         value_in = head_value;
      end else begin
         value_in = value_ff;
      end
   end

   // Entry storage; payload only, so no reset.
   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value_out = value_ff;

endmodule

### sv/bounded_list_insert_delete_dump.sv
// Timing: the list is updated at the edge that accepts a request beat; the
// response beats then leave the output register, one beat per cycle while
// rsp_tready is held high. A new request is taken only once the dump ends;
// the dump rotates the cell row once per response beat.
// Reset: synchronous, active high; the list becomes empty, entries keep
// whatever they held.
// ----------------------------------------------------------------------------
// Bounded list with front insert, back append and positional delete
// A row of cells holds the list. Each request updates the row on acceptance,
// then the whole list is streamed out by rotating the occupied cells.
// ----------------------------------------------------------------------------
module bounded_list_insert_delete_dump #(
   parameter int CAPACITY = blid_pkg::CAPACITY_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // Request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [31:0] value, [39:32] position
   input  logic [1:0]  req_tuser,   // [1:0] operation
   // Response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] element, [35:32] element_index, rest 0
   output logic        rsp_tlast,
   output logic [1:0]  rsp_tuser    // [0] list_empty, [1] overflow
);

   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int PCW  = (CW > blid_pkg::POSITION_W) ? CW : blid_pkg::POSITION_W;
   localparam int VW   = blid_pkg::VALUE_W;

   // Request fields.
   logic signed [VW-1:0]                  req_value;
   logic [blid_pkg::POSITION_W-1:0]       req_position;
   blid_pkg::op_type                      req_op;

   assign req_value    = req_tdata[31:0];
   assign req_position = req_tdata[39:32];
   assign req_op       = blid_pkg::op_type'(req_tuser);

   // Control state.
   blid_pkg::state_type state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic                ovf_ff, ovf_in;

   // Output register.
   logic                      out_valid_ff, out_valid_in;
   logic signed [VW-1:0]      out_element_ff, out_element_in;
   logic [blid_pkg::INDEX_W-1:0] out_index_ff, out_index_in;
   logic                      out_last_ff, out_last_in;
   logic                      out_empty_ff, out_empty_in;
   logic                      out_ovf_ff, out_ovf_in;

   logic req_fire;
   logic beat_go;
   logic dump_active;
   logic list_full;
   logic list_is_empty;
   logic last_beat;
   logic del_hit;

   // Cell row.
   logic [VW-1:0]          cell_value [CAPACITY];
   blid_pkg::cell_ctl_type cell_ctl   [CAPACITY];

   assign req_fire      = req_tvalid && req_tready;
   assign list_full     = (count_ff == CW'(CAPACITY));
   assign list_is_empty = (count_ff == '0);
   assign last_beat     = list_is_empty || (idx_ff == (count_ff - CW'(1)));
   assign del_hit       = (PCW'(req_position) < PCW'(count_ff));
   assign beat_go       = dump_active && (!out_valid_ff || rsp_tready);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         blid_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = blid_pkg::ST_DUMP;
            end
         end
         blid_pkg::ST_DUMP: begin
            if (beat_go && last_beat) begin
               state_in = blid_pkg::ST_IDLE;
            end
         end
         default: state_in = blid_pkg::ST_IDLE;
      endcase
   end

   // State outputs.
   always_comb begin
      req_tready  = 1'b0;
      dump_active = 1'b0;
      unique case (state_ff)
         blid_pkg::ST_IDLE: req_tready  = 1'b1;
         blid_pkg::ST_DUMP: dump_active = 1'b1;
         default: begin
            req_tready  = 1'b0;
            dump_active = 1'b0;
         end
      endcase
   end

   // Length, overflow flag and dump index.
   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      idx_in   = idx_ff;
      if (req_fire) begin
         ovf_in = 1'b0;
         idx_in = '0;
         case (req_op)
            blid_pkg::OP_INSERT_FRONT, blid_pkg::OP_APPEND_BACK: begin
               if (list_full) begin
                  ovf_in = 1'b1;
               end else begin
                  count_in = count_ff + CW'(1);
               end
            end
            blid_pkg::OP_DELETE_AT: begin
               if (del_hit) begin
                  count_in = count_ff - CW'(1);
               end
            end
            default: count_in = count_ff;
         endcase
      end else if (beat_go) begin
         idx_in = last_beat ? '0 : idx_ff + CW'(1);
      end
   end

   // Per-cell control words.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_ctl
      always_comb begin
         cell_ctl[i] = '0;
         if (req_fire) begin
            case (req_op)
               blid_pkg::OP_INSERT_FRONT: begin
                  if (!list_full) begin
                     cell_ctl[i].load      = (i == 0);
                     cell_ctl[i].take_left = (i != 0);
                  end
               end
               blid_pkg::OP_APPEND_BACK: begin
                  if (!list_full) begin
                     cell_ctl[i].load = (CW'(i) == count_ff);
                  end
               end
               blid_pkg::OP_DELETE_AT: begin
                  if (del_hit) begin
                     cell_ctl[i].take_right = (PCW'(i) >= PCW'(req_position));
                  end
               end
               default: cell_ctl[i] = '0;
            endcase
         end else if (beat_go && !list_is_empty) begin
            // Rotate the occupied cells so the next entry reaches the head.
            cell_ctl[i].take_right = (CW'(i) < (count_ff - CW'(1)));
            cell_ctl[i].take_head  = (CW'(i) == (count_ff - CW'(1)));
         end
      end
   end

   // Cell row; the first and last cells see zero beyond the row ends.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [VW-1:0] left_v;
      logic [VW-1:0] right_v;
      if (i == 0) begin : g_first
         assign left_v = '0;
      end else begin : g_mid_l
         assign left_v = cell_value[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_v = '0;
      end else begin : g_mid_r
         assign right_v = cell_value[i+1];
      end
      blid_cell u_cell (
         .clock       (clock),
         .ctl         (cell_ctl[i]),
         .load_value  (req_value),
         .left_value  (left_v),
         .right_value (right_v),
         .head_value  (cell_value[0]),
         .value_out   (cell_value[i])
      );
   end

   // Output register loads one beat from the head cell.
   always_comb begin
      out_valid_in   = out_valid_ff;
      out_element_in = out_element_ff;
      out_index_in   = out_index_ff;
      out_last_in    = out_last_ff;
      out_empty_in   = out_empty_ff;
      out_ovf_in     = out_ovf_ff;
      if (beat_go) begin
         out_valid_in   = 1'b1;
         out_element_in = list_is_empty ? '0 : cell_value[0];
         out_index_in   = blid_pkg::INDEX_W'(idx_ff);
         out_last_in    = last_beat;
         out_empty_in   = list_is_empty;
         out_ovf_in     = ovf_ff;
      end else if (rsp_tready) begin
         out_valid_in   = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= blid_pkg::ST_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         ovf_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         ovf_ff       <= ovf_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      out_element_ff <= out_element_in;
      out_index_ff   <= out_index_in;
      out_last_ff    <= out_last_in;
      out_empty_ff   <= out_empty_in;
      out_ovf_ff     <= out_ovf_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0, out_index_ff, out_element_ff};
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = {out_ovf_ff, out_empty_ff};

   // The list never grows past its capacity.
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("list length exceeds capacity");

   // An empty-list beat is always the final beat of its dump.
   a_empty_last : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_empty_ff) |-> out_last_ff)
      else $error("empty beat not marked last");

   // Every accepted request starts a dump.
   a_fire_dump : assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == blid_pkg::ST_DUMP))
      else $error("request accepted without a dump");

endmodule

### test/tb_top.sv
// ----------------------------------------------------------------------------
// Bounded list testbench
// Drives front inserts, back appends, positional deletes and the unused
// operation code into the list block. A shadow copy of the list predicts
// every dump beat, and each response beat is compared field by field in
// arrival order. Both stream sides idle at random, the receiver holds off
// once for a long stretch, and the sender pauses once until the block drains.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int          LIST_DEPTH  = blid_pkg::CAPACITY_DEF;
   localparam logic [1:0]  OP_RESERVED = 2'd3;
   localparam int          MAX_PRINTS  = 30;

   // One predicted response beat.
   typedef struct packed {
      logic [31:0] element;
      logic [3:0]  element_index;
      logic        last;
      logic        list_empty;
      logic        overflow;
   } dump_beat_type;

   // Shadow list and the queue of dump beats still owed by the block.
   class list_dump_board;
      logic [31:0]   shadow_list[$];
      dump_beat_type expected_dump[$];
      int            mismatch_count;

      function new();
         mismatch_count = 0;
      endfunction

      task report(string what);
         mismatch_count++;
         if (mismatch_count <= MAX_PRINTS) begin
            $display("%0t: mismatch: %s", $time, what);
         end
      endtask

      // Apply an accepted request beat and queue the dump it causes.
      task note_request(logic [1:0] opcode, logic [31:0] value, logic [7:0] position);
         logic          dropped;
         dump_beat_type beat;
         dropped = 1'b0;
         case (opcode)
            blid_pkg::OP_INSERT_FRONT: begin
               if (shadow_list.size() >= LIST_DEPTH) dropped = 1'b1;
               else shadow_list.push_front(value);
            end
            blid_pkg::OP_APPEND_BACK: begin
               if (shadow_list.size() >= LIST_DEPTH) dropped = 1'b1;
               else shadow_list.push_back(value);
            end
            blid_pkg::OP_DELETE_AT: begin
               if (position < shadow_list.size()) shadow_list.delete(position);
            end
            default: ;
         endcase
         if (shadow_list.size() == 0) begin
            beat = '{element: '0, element_index: '0, last: 1'b1, list_empty: 1'b1,
                     overflow: dropped};
            expected_dump.push_back(beat);
         end else begin
            for (int i = 0; i < shadow_list.size(); i++) begin
               beat = '{element: shadow_list[i], element_index: i[3:0],
                        last: (i == shadow_list.size() - 1), list_empty: 1'b0,
                        overflow: dropped};
               expected_dump.push_back(beat);
            end
         end
      endtask

      // Compare one accepted response beat with the oldest prediction.
      task check_beat(logic [39:0] data, logic last, logic [1:0] flags);
         dump_beat_type want;
         if (expected_dump.size() == 0) begin
            report($sformatf("unexpected beat data=%h last=%b user=%b", data, last, flags));
         end else begin
            want = expected_dump.pop_front();
            if (data[31:0] !== want.element)
               report($sformatf("element %h, predicted %h", data[31:0], want.element));
            if (data[35:32] !== want.element_index)
               report($sformatf("element_index %0d, predicted %0d", data[35:32],
                                want.element_index));
            if (data[39:36] !== 4'd0)
               report($sformatf("tdata padding %h, predicted 0", data[39:36]));
            if (last !== want.last)
               report($sformatf("last %b, predicted %b", last, want.last));
            if (flags[0] !== want.list_empty)
               report($sformatf("list_empty %b, predicted %b", flags[0], want.list_empty));
            if (flags[1] !== want.overflow)
               report($sformatf("overflow %b, predicted %b", flags[1], want.overflow));
         end
      endtask
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;   // [31:0] value, [39:32] position
   logic [1:0]  req_tuser  = '0;   // [1:0] operation
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;         // [31:0] element, [35:32] element_index, rest 0
   logic        rsp_tlast;
   logic [1:0]  rsp_tuser;         // [0] list_empty, [1] overflow

   list_dump_board board = new();
   int             no_idle     = 0;
   int             hold_cycles = 0;

   bounded_list_insert_delete_dump i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // Clock and the single reset pulse.
   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   // Watchdog for a hung block.
   initial begin
      #2_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   // Beats seen at each edge: requests update the shadow list before the
   // response beat of the same edge is checked.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) board.note_request(req_tuser, req_tdata[31:0],
                                                          req_tdata[39:32]);
         if (rsp_tvalid && rsp_tready) board.check_beat(rsp_tdata, rsp_tlast, rsp_tuser);
      end
   end

   // Response side: random stall before each beat, plus the long hold-off
   // when one is requested.
   initial begin
      int stall;
      forever begin
         if (hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end
         stall = no_idle ? 0 : $urandom_range(0, 4);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Offer one request beat after a random gap and wait until it is taken.
   task send_request(logic [1:0] opcode, logic [31:0] value, logic [7:0] position);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {position, value};
      req_tuser  <= opcode;
      do @(posedge clock); while (!req_tready);
   endtask

   // Random request; grow_pct sets how often the list gets an insert.
   task send_random(int grow_pct);
      int          pick;
      logic [1:0]  opcode;
      logic [31:0] value;
      logic [7:0]  position;
      pick = $urandom_range(0, 99);
      if (pick < 5) opcode = OP_RESERVED;
      else if (pick < 5 + grow_pct)
         opcode = ($urandom_range(0, 1) == 0) ? blid_pkg::OP_INSERT_FRONT
                                               : blid_pkg::OP_APPEND_BACK;
      else opcode = blid_pkg::OP_DELETE_AT;
      case ($urandom_range(0, 7))
         0: value = 32'h7FFF_FFFF;
         1: value = 32'h8000_0000;
         default: value = $urandom;
      endcase
      // Deletes mostly hit the list or its first free slot.
      if (opcode == blid_pkg::OP_DELETE_AT && $urandom_range(0, 4) != 0)
         position = 8'($urandom_range(0, board.shadow_list.size()));
      else
         position = 8'($urandom_range(0, 255));
      send_request(opcode, value, position);
   endtask

   // Stop offering and wait until the block has delivered every beat.
   task wait_for_dump_drain(int limit);
      int n;
      n = 0;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.expected_dump.size() != 0 && n < limit) begin
         @(posedge clock);
         n++;
      end
   endtask

   // Stimulus sequence.
   initial begin
      int grow;
      @(negedge reset);
      @(posedge clock);

      // Empty list cases, extreme values, deletes around the boundary.
      send_request(blid_pkg::OP_DELETE_AT, 32'h1234_5678, 8'd0);
      send_request(OP_RESERVED, 32'hFFFF_FFFF, 8'hFF);
      send_request(blid_pkg::OP_INSERT_FRONT, 32'h7FFF_FFFF, 8'hFF);
      send_request(blid_pkg::OP_APPEND_BACK, 32'h8000_0000, 8'h00);
      send_request(blid_pkg::OP_DELETE_AT, 32'hFFFF_FFFF, 8'd255);
      send_request(blid_pkg::OP_DELETE_AT, 32'h0, 8'd2);
      send_request(blid_pkg::OP_DELETE_AT, 32'h0, 8'd1);
      send_request(blid_pkg::OP_DELETE_AT, 32'h0, 8'd0);
      // Fill to capacity, then insert and append into the full list.
      for (int i = 0; i < LIST_DEPTH; i++) begin
         send_request((i % 2 == 0) ? blid_pkg::OP_APPEND_BACK : blid_pkg::OP_INSERT_FRONT,
                      (i == 3) ? 32'hFFFF_FFFF : $urandom, 8'($urandom_range(0, 255)));
      end
      send_request(blid_pkg::OP_INSERT_FRONT, 32'h0000_0001, 8'd0);
      send_request(blid_pkg::OP_APPEND_BACK, 32'hFFFF_FFFE, 8'd7);

      // Random phases that push the list toward full, empty and the middle.
      for (int p = 0; p < 12; p++) begin
         no_idle = (p % 4 == 3);
         grow = (p % 3 == 0) ? 80 : ((p % 3 == 1) ? 15 : 48);
         repeat (30) send_random(grow);
      end

      // Receiver holds off while requests keep coming.
      no_idle = 1;
      hold_cycles = 300;
      repeat (20) send_random(50);
      no_idle = 0;
      wait_for_dump_drain(5000);

      repeat (54) send_random(45);

      wait_for_dump_drain(5000);
      repeat (20) @(posedge clock);
      if (board.expected_dump.size() != 0)
         board.report($sformatf("%0d predicted beats never arrived",
                                board.expected_dump.size()));
      if (board.mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
